// ----- rtl/core/svcb_pkg.sv -----
package svcb_pkg;

    localparam int unsigned PcBitsDefault = 16;
    localparam int unsigned CmdBits = 5;
    localparam int unsigned ValBits = 64;
    localparam int unsigned OffBits = 16;

    localparam logic [CmdBits-1:0] CmdLcmp = 5'd0;
    localparam logic [CmdBits-1:0] CmdDcmpg = 5'd1;
    localparam logic [CmdBits-1:0] CmdDcmpl = 5'd2;
    localparam logic [CmdBits-1:0] CmdIfeq = 5'd3;
    localparam logic [CmdBits-1:0] CmdIfne = 5'd4;
    localparam logic [CmdBits-1:0] CmdIflt = 5'd5;
    localparam logic [CmdBits-1:0] CmdIfle = 5'd6;
    localparam logic [CmdBits-1:0] CmdIfgt = 5'd7;
    localparam logic [CmdBits-1:0] CmdIfge = 5'd8;
    localparam logic [CmdBits-1:0] CmdIcmpeq = 5'd9;
    localparam logic [CmdBits-1:0] CmdIcmpne = 5'd10;
    localparam logic [CmdBits-1:0] CmdIcmplt = 5'd11;
    localparam logic [CmdBits-1:0] CmdIcmple = 5'd12;
    localparam logic [CmdBits-1:0] CmdIcmpgt = 5'd13;
    localparam logic [CmdBits-1:0] CmdIcmpge = 5'd14;
    localparam logic [CmdBits-1:0] CmdAcmpeq = 5'd15;
    localparam logic [CmdBits-1:0] CmdAcmpne = 5'd16;

    localparam logic [1:0] CresLess = 2'b11;
    localparam logic [1:0] CresEqual = 2'b00;
    localparam logic [1:0] CresGreater = 2'b01;

    typedef struct packed {
        logic [1:0] compare_result;
        logic       writes_compare;
        logic       branch_taken;
        logic [1:0] pop_count;
    } t_flags;

endpackage

// ----- rtl/core/stack_vm_compare_branch_unit.sv -----
// An input register and a result register lie between input transfer and result.
// Throughput: one item per cycle while i_ready is high, set by the single-pass compare logic.
// Both stages accept a new transfer while the stage after them drains in the same cycle.
// Reset (synchronous, active low) clears the valid flags; payload registers keep no reset.
module stack_vm_compare_branch_unit
    import svcb_pkg::*;
#(
    parameter int unsigned PC_BITS = PcBitsDefault
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [CmdBits-1:0]        i_cmd,
    input  logic signed [ValBits-1:0] i_first_value,
    input  logic signed [ValBits-1:0] i_second_value,
    input  logic [PC_BITS-1:0]        i_current_pc,
    input  logic signed [OffBits-1:0] i_branch_offset,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [1:0]         o_compare_result,
    output logic                      o_writes_compare,
    output logic                      o_branch_taken,
    output logic [PC_BITS-1:0]        o_next_pc,
    output logic [1:0]                o_pop_count
);

    logic                      r_in_valid;
    logic [CmdBits-1:0]        r_cmd;
    logic signed [ValBits-1:0] r_first;
    logic signed [ValBits-1:0] r_second;
    logic [PC_BITS-1:0]        r_pc;
    logic signed [OffBits-1:0] r_off;
    logic                      r_out_valid;
    t_flags                    r_flags;
    logic [PC_BITS-1:0]        r_next_pc;
    t_flags                    n_flags;
    logic [PC_BITS-1:0]        n_next_pc;
    logic                      out_free;
    logic                      in_free;

    assign out_free = !r_out_valid || i_ready;
    assign in_free = !r_in_valid || out_free;
    assign o_ready = in_free;

    svcb_exec #(.PC_BITS(PC_BITS)) u_exec (
        .i_cmd          (r_cmd),
        .i_first_value  (r_first),
        .i_second_value (r_second),
        .i_current_pc   (r_pc),
        .i_branch_offset(r_off),
        .o_flags        (n_flags),
        .o_next_pc      (n_next_pc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_free) begin
                r_in_valid <= i_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
        if (in_free && i_valid) begin
            r_cmd <= i_cmd;
            r_first <= i_first_value;
            r_second <= i_second_value;
            r_pc <= i_current_pc;
            r_off <= i_branch_offset;
        end
        if (out_free && r_in_valid) begin
            r_flags <= n_flags;
            r_next_pc <= n_next_pc;
        end
    end

    assign o_valid = r_out_valid;
    assign o_compare_result = r_flags.compare_result;
    assign o_writes_compare = r_flags.writes_compare;
    assign o_branch_taken = r_flags.branch_taken;
    assign o_next_pc = r_next_pc;
    assign o_pop_count = r_flags.pop_count;

endmodule

// ----- rtl/core/svcb_exec.sv -----
module svcb_exec
    import svcb_pkg::*;
#(
    parameter int unsigned PC_BITS = PcBitsDefault
) (
    input  logic [CmdBits-1:0]        i_cmd,
    input  logic signed [ValBits-1:0] i_first_value,
    input  logic signed [ValBits-1:0] i_second_value,
    input  logic [PC_BITS-1:0]        i_current_pc,
    input  logic signed [OffBits-1:0] i_branch_offset,
    output t_flags                    o_flags,
    output logic [PC_BITS-1:0]        o_next_pc
);

    logic [ValBits-1:0] a;
    logic [ValBits-1:0] b;
    logic               l_gt;
    logic               l_eq;
    logic               d_nan;
    logic               d_eq;
    logic               d_gt;
    logic               a_mag_gt;
    logic               b_mag_gt;
    logic               both_zero;
    logic               z_eq;
    logic               z_lt;
    logic               i_eq;
    logic               i_lt;
    logic               cond;
    logic [1:0]         cres;
    logic [PC_BITS-1:0] taken_pc;
    logic [PC_BITS-1:0] skip_pc;

    assign a = i_first_value;
    assign b = i_second_value;

    assign l_eq = (a == b);
    assign l_gt = ($signed(a) > $signed(b));

    assign d_nan = ((&a[62:52]) && (|a[51:0])) || ((&b[62:52]) && (|b[51:0]));
    assign both_zero = (a[62:0] == 63'd0) && (b[62:0] == 63'd0);
    assign a_mag_gt = (a[62:0] > b[62:0]);
    assign b_mag_gt = (b[62:0] > a[62:0]);
    assign d_eq = both_zero || l_eq;
    always_comb begin
        if (a[63] != b[63]) begin
            d_gt = !a[63];
        end else if (a[63]) begin
            d_gt = b_mag_gt;
        end else begin
            d_gt = a_mag_gt;
        end
    end

    assign z_eq = (b[31:0] == 32'd0);
    assign z_lt = b[31];
    assign i_eq = (a[31:0] == b[31:0]);
    assign i_lt = ($signed(a[31:0]) < $signed(b[31:0]));

    always_comb begin
        cres = CresEqual;
        if (i_cmd == CmdLcmp) begin
            cres = l_eq ? CresEqual : (l_gt ? CresGreater : CresLess);
        end else if (d_nan) begin
            cres = (i_cmd == CmdDcmpg) ? CresGreater : CresLess;
        end else begin
            cres = d_eq ? CresEqual : (d_gt ? CresGreater : CresLess);
        end
    end

    always_comb begin
        case (i_cmd)
            CmdIfeq:   cond = z_eq;
            CmdIfne:   cond = !z_eq;
            CmdIflt:   cond = z_lt;
            CmdIfle:   cond = z_lt || z_eq;
            CmdIfgt:   cond = !z_lt && !z_eq;
            CmdIfge:   cond = !z_lt;
            CmdIcmpeq: cond = i_eq;
            CmdIcmpne: cond = !i_eq;
            CmdIcmplt: cond = i_lt;
            CmdIcmple: cond = i_lt || i_eq;
            CmdIcmpgt: cond = !i_lt && !i_eq;
            CmdIcmpge: cond = !i_lt;
            CmdAcmpeq: cond = l_eq;
            CmdAcmpne: cond = !l_eq;
            default:   cond = 1'b0;
        endcase
    end

    assign taken_pc = i_current_pc - PC_BITS'(1)
        + PC_BITS'($signed({{(32-OffBits){i_branch_offset[OffBits-1]}}, i_branch_offset}));
    assign skip_pc = i_current_pc + PC_BITS'(2);

    always_comb begin
        o_flags = '0;
        o_next_pc = i_current_pc;
        if (i_cmd <= CmdDcmpl) begin
            o_flags.compare_result = cres;
            o_flags.writes_compare = 1'b1;
            o_flags.pop_count = 2'd1;
        end else if (i_cmd <= CmdAcmpne) begin
            o_flags.branch_taken = cond;
            o_flags.pop_count = (i_cmd <= CmdIfge) ? 2'd1 : 2'd2;
            o_next_pc = cond ? taken_pc : skip_pc;
        end
    end

endmodule
